// ===== hw/rtl/terminal_key_sequence_parser_macros.svh =====
// Assertion macros shared by the terminal key sequence parser RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef TERMINAL_KEY_SEQUENCE_PARSER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKSP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tksp_pkg.sv =====
// Package for the terminal key sequence parser: sizes, codes, key table and helpers.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tksp_pkg;

   // Store sizing: at most BUF_BYTES-1 bytes are ever held.
   localparam int BUF_BYTES   = 8;
   localparam int ADDR_W      = $clog2(BUF_BYTES);
   localparam int LEVEL_W     = 3;
   localparam int NUM_KEYS    = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [7:0]          data_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [NUM_KEYS-1:0] mask_type;
   typedef logic [4:0]          status_type;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_STRIP  = 2'd2,
      ACT_OUTPUT = 2'd3
   } action_type;

   // Result word kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_LEVEL  = 2'd2;

   // Push status codes outside the key codes.
   localparam status_type ST_NEED_MORE = 5'd0;
   localparam status_type ST_NO_CMD    = 5'd1;
   localparam status_type ST_FULL      = 5'd17;

   // Classified command passed from the front to the back.
   typedef struct packed {
      action_type op;
      data_type   data;
      addr_type   limit;
   } cmd_type;

   // Key table, scanned in order; byte j of a sequence sits at bits [8*j +: 8].
   localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
      3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1
   };
   localparam logic [31:0] KEY_SEQ [NUM_KEYS] = '{
      32'h0000_007F, 32'h0000_0009, 32'h0000_000A, 32'h0000_000D,
      32'h0044_5B1B, 32'h0043_5B1B, 32'h0041_5B1B, 32'h0042_5B1B,
      32'h0048_5B1B, 32'h7E31_5B1B, 32'h0046_5B1B, 32'h7E34_5B1B,
      32'h7E33_5B1B, 32'h7E32_5B1B, 32'h7E35_5B1B, 32'h7E36_5B1B,
      32'h0000_0003
   };
   localparam status_type KEY_CODE [NUM_KEYS] = '{
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
      5'd10, 5'd11, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
   };

   // Narrow a candidate set by one more byte placed at position pos.
   function automatic mask_type key_mask_step(mask_type mask, addr_type pos, data_type b);
      mask_type nxt;
      begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            nxt[i] = mask[i] && (pos < ADDR_W'(KEY_LEN[i]))
                     && (KEY_SEQ[i][{pos[1:0], 3'b000} +: 8] == b);
         end
         return nxt;
      end
   endfunction

   // First surviving entry decides: full length gives its code, else need more.
   function automatic status_type key_status(mask_type mask, addr_type len);
      status_type st;
      begin
         st = ST_NO_CMD;
         for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (mask[i]) begin
               st = (ADDR_W'(KEY_LEN[i]) == len) ? KEY_CODE[i] : ST_NEED_MORE;
            end
         end
         return st;
      end
   endfunction

   function automatic logic is_printable(data_type b);
      return (b >= 8'h20) && (b <= 8'h7E);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tksp_front.sv =====
// Front end of the key sequence parser: takes request words and classifies them.
// Depends on tksp_pkg; feeds tksp_queue.
`default_nettype none

module tksp_front import tksp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_truncate_at,
   output logic            q_valid,
   input  wire logic       q_ready,
   output cmd_type         q_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    load;

   // The holding register frees up as soon as the queue takes its word.
   assign req_ready = !valid_ff || q_ready;
   assign load      = req_valid && req_ready;

   // Decode the action and saturate the length limit to what the store can hold.
   always_comb begin
      cmd_in      = cmd_ff;
      cmd_in.op   = action_type'(req_action);
      cmd_in.data = req_data_byte;
      if (req_truncate_at > 8'(BUF_BYTES - 1)) begin
         cmd_in.limit = ADDR_W'(BUF_BYTES - 1);
      end else begin
         cmd_in.limit = req_truncate_at[ADDR_W-1:0];
      end
      valid_in = load ? 1'b1 : (valid_ff && !q_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_cmd   = cmd_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tksp_queue.sv =====
// Short command queue between the front and back of the key sequence parser.
// Depends on tksp_pkg for the command type and depth.
`default_nettype none

module tksp_queue import tksp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  cmd_type   in_cmd,
   output logic      out_valid,
   input  wire logic out_ready,
   output cmd_type   out_cmd
);

   cmd_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = mem[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tksp_back.sv =====
// Back end of the key sequence parser: byte store, key matcher and result sequencer.
// Depends on tksp_pkg; takes commands from tksp_queue and drives the rsp_ channel.
`default_nettype none

module tksp_back import tksp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   output logic            q_ready,
   input  cmd_type         q_cmd,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [4:0]      rsp_status,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_empty,
   output logic            rsp_last,
   output logic [2:0]      rsp_level
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PUSH   = 6'b000010,
      S_REPORT = 6'b000100,
      S_EMPTY  = 6'b001000,
      S_FETCH  = 6'b010000,
      S_PROC   = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   action_type     op_ff, op_in;
   data_type       data_ff, data_in;
   addr_type       n_ff, n_in, idx_ff, idx_in, wr_ff, wr_in, fill_ff, fill_in;
   mask_type       mask_ff, mask_in;
   data_type       rd_data_ff;
   data_type       mem [BUF_BYTES];

   logic           mem_we, rd_en;
   addr_type       mem_waddr;
   data_type       mem_wdata;

   logic           rsp_valid_ff, rsp_valid_in, rsp_is_empty_ff, rsp_is_empty_in;
   logic           rsp_last_ff, rsp_last_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   status_type     rsp_status_ff, rsp_status_in;
   data_type       rsp_out_byte_ff, rsp_out_byte_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   logic           emit_ok, final_idx, keep;
   mask_type       push_mask, strip_mask;
   addr_type       out_count, fill_plus;

   // The result register can take a new word when empty or being drained.
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign q_ready   = (state_ff == S_IDLE);
   assign final_idx = (idx_ff == n_ff - ADDR_W'(1));
   assign fill_plus = fill_ff + ADDR_W'(1);
   assign push_mask  = key_mask_step(mask_ff, fill_ff, data_ff);
   assign strip_mask = key_mask_step(mask_ff, wr_ff, rd_data_ff);
   assign out_count  = (fill_ff < q_cmd.limit) ? fill_ff : q_cmd.limit;
   // During a strip the final held byte survives whenever more than one was held.
   assign keep = is_printable(rd_data_ff) || (final_idx && (n_ff > ADDR_W'(1)));

   // Sequencer: one command at a time, one stored byte per fetch and process pair.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      data_in         = data_ff;
      n_in            = n_ff;
      idx_in          = idx_ff;
      wr_in           = wr_ff;
      fill_in         = fill_ff;
      mask_in         = mask_ff;
      mem_we          = 1'b0;
      mem_waddr       = fill_ff;
      mem_wdata       = data_ff;
      rd_en           = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_level_in    = rsp_level_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               op_in   = q_cmd.op;
               data_in = q_cmd.data;
               idx_in  = '0;
               wr_in   = '0;
               unique case (q_cmd.op)
                  ACT_PUSH: begin
                     state_in = S_PUSH;
                  end
                  ACT_CLEAR: begin
                     fill_in  = '0;
                     mask_in  = '1;
                     state_in = S_REPORT;
                  end
                  ACT_STRIP: begin
                     n_in     = fill_ff;
                     mask_in  = '1;
                     state_in = (fill_ff == '0) ? S_REPORT : S_FETCH;
                  end
                  ACT_OUTPUT: begin
                     n_in     = out_count;
                     fill_in  = '0;
                     mask_in  = '1;
                     state_in = (out_count == '0) ? S_EMPTY : S_FETCH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (emit_ok) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = KIND_STATUS;
               rsp_out_byte_in = '0;
               rsp_is_empty_in = 1'b0;
               rsp_last_in     = 1'b1;
               if (fill_ff >= ADDR_W'(BUF_BYTES - 1)) begin
                  rsp_status_in = ST_FULL;
                  rsp_level_in  = fill_ff[LEVEL_W-1:0];
               end else begin
                  mem_we        = 1'b1;
                  fill_in       = fill_plus;
                  mask_in       = push_mask;
                  rsp_status_in = key_status(push_mask, fill_plus);
                  rsp_level_in  = fill_plus[LEVEL_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         S_REPORT: begin
            if (emit_ok) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = KIND_LEVEL;
               rsp_status_in   = ST_NEED_MORE;
               rsp_out_byte_in = '0;
               rsp_is_empty_in = 1'b0;
               rsp_last_in     = 1'b1;
               rsp_level_in    = fill_ff[LEVEL_W-1:0];
               state_in        = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (emit_ok) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = KIND_DATA;
               rsp_status_in   = ST_NEED_MORE;
               rsp_out_byte_in = '0;
               rsp_is_empty_in = 1'b1;
               rsp_last_in     = 1'b1;
               rsp_level_in    = '0;
               state_in        = S_IDLE;
            end
         end
         S_FETCH: begin
            rd_en    = 1'b1;
            state_in = S_PROC;
         end
         S_PROC: begin
            if (op_ff == ACT_OUTPUT) begin
               // Emit one held byte per word, the final one marked.
               if (emit_ok) begin
                  rsp_valid_in    = 1'b1;
                  rsp_kind_in     = KIND_DATA;
                  rsp_status_in   = ST_NEED_MORE;
                  rsp_out_byte_in = rd_data_ff;
                  rsp_is_empty_in = 1'b0;
                  rsp_last_in     = final_idx;
                  rsp_level_in    = '0;
                  if (final_idx) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + ADDR_W'(1);
                     state_in = S_FETCH;
                  end
               end
            end else begin
               // Compact kept bytes in place and rebuild the candidate set.
               if (keep) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ff;
                  mem_wdata = rd_data_ff;
                  wr_in     = wr_ff + ADDR_W'(1);
                  mask_in   = strip_mask;
               end
               if (final_idx) begin
                  fill_in  = keep ? wr_ff + ADDR_W'(1) : wr_ff;
                  state_in = S_REPORT;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         mask_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      data_ff         <= data_in;
      n_ff            <= n_in;
      idx_ff          <= idx_in;
      wr_ff           <= wr_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_level_ff    <= rsp_level_in;
   end

   // Byte store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_level    = rsp_level_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/terminal_key_sequence_parser.sv =====
// Terminal key sequence parser: a request word pushes a received byte, clears,
// strips control bytes from, or drains a small byte store. The req_ channel
// carries action, data byte and length limit; the rsp_ channel returns result
// words: a push status, one word per drained byte, or a level report.
// A request is registered by the front end and passes a two-entry queue to the
// back end, so up to three further requests are taken while the back end works.
// With rsp_ready high, a push, a clear, a strip of an empty store or an empty
// output passes the front register and the queue and then occupies the back
// end for one result state. A strip and an output take a fetch and a process
// state for each held or emitted byte, set by the single-port byte store with
// its registered read; a strip then ends with its level report.
// Reset is synchronous and empties the store and queue; no clearing pass follows.
// When rsp_ready is low the result register holds its word and the back end
// waits; requests keep being taken until the queue and front register are full.
// Depends on tksp_pkg, tksp_front, tksp_queue and tksp_back.
`default_nettype none
`include "terminal_key_sequence_parser_macros.svh"

module terminal_key_sequence_parser import tksp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_truncate_at,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [4:0]      rsp_status,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_empty,
   output logic            rsp_last,
   output logic [2:0]      rsp_level
);

   logic    front_valid, front_ready, back_valid, back_ready;
   cmd_type front_cmd, back_cmd;

   // Front end: request register and classification.
   tksp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .req_truncate_at (req_truncate_at),
      .q_valid         (front_valid),
      .q_ready         (front_ready),
      .q_cmd           (front_cmd)
   );

   // Command queue decoupling the two halves.
   tksp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   // Back end: store, matcher and result sequencer.
   tksp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (back_valid),
      .q_ready      (back_ready),
      .q_cmd        (back_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_status   (rsp_status),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_empty (rsp_is_empty),
      .rsp_last     (rsp_last),
      .rsp_level    (rsp_level)
   );

   // Checks on the result sequencing and the internal command hand-over.
   `TKSP_ASSERT_IMP(a_status_single, rsp_valid && rsp_kind == KIND_STATUS, rsp_last, "push status word not marked last")
   `TKSP_ASSERT_IMP(a_empty_word, rsp_valid && rsp_is_empty, rsp_last && rsp_kind == KIND_DATA && rsp_out_byte == 8'h00, "malformed empty output word")
   `TKSP_ASSERT_IMP(a_drain_level, rsp_valid && rsp_kind == KIND_DATA, rsp_level == 3'd0, "drained byte word reports a non-zero level")
   `TKSP_ASSERT_NEXT(a_cmd_held, front_valid && !front_ready, front_valid && $stable(front_cmd), "command lost while queue full")

endmodule

`default_nettype wire
